@@ rtl/coim_pkg.sv @@
// ----------------------------------------------------------------------------
// coim_pkg: shared definitions of the coefficient index order mapper
// Field widths, register indexes, function codes and the pipeline types.
// ----------------------------------------------------------------------------
package coim_pkg;

   // Field widths of the request and response items.
   localparam int IDX_W = 18;
   localparam int BLK_W = 2;
   localparam int RAD_W = 6;
   localparam int DEG_W = 5;

   localparam int NUM_BLOCKS_DEF = 4;

   // (L+1)^2 needs one bit more than twice the degree width.
   localparam int SQ_W   = 2 * DEG_W + 1;
   // l*l + 2m stays below (2^DEG_W)^2.
   localparam int LSQ_W  = 2 * DEG_W;
   localparam int SIZE_W = RAD_W + 2 * DEG_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = RAD_W;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIAL_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEGREE_0 = 3'd4;

   typedef enum logic {
      FUNC_DECODE = 1'b0,
      FUNC_ENCODE = 1'b1
   } func_type;

   typedef struct packed {
      func_type         func;
      logic [IDX_W-1:0] idx;
      logic [BLK_W-1:0] sel;
      logic [RAD_W-1:0] n;
      logic [DEG_W-1:0] l;
      logic [DEG_W-1:0] m;
      logic             re;
   } req_type;

   // Front stages: order checks and the encode arithmetic.
   typedef struct packed {
      logic              valid;
      func_type          func;
      logic              err;
      logic [BLK_W-1:0]  blk;
      logic [IDX_W-1:0]  idx;
      logic [RAD_W-1:0]  nm1;
      logic [LSQ_W-1:0]  lsqm;
      logic [SIZE_W-1:0] prod;
   } front_type;

   // Back stages: block offset, divider and square root.
   typedef struct packed {
      logic             valid;
      func_type         func;
      logic             err;
      logic [BLK_W-1:0] blk;
      logic [IDX_W-1:0] rem;
      logic [RAD_W-1:0] quo;
      logic [DEG_W-1:0] root;
   } tok_type;

endpackage

@@ rtl/coefficient_index_order_mapper.sv @@
// ----------------------------------------------------------------------------
// coefficient_index_order_mapper: flat coefficient index <-> order mapping
// Decodes a flat index into (block, n, l, m, part) and encodes the orders
// back into a flat index, over up to four packed parameter blocks.
//
//   channel   ports                      transfer
//   request   start/busy, req_*          start high while busy is low
//   response  rsp_strobe, rsp_*          every cycle rsp_strobe is high
//   config    csr_we, csr_index, csr_wdata   every cycle csr_we is high
//
// One item enters per cycle while busy is low; its result passes the front
// stages, the restoring divider (one quotient bit per stage) and the square
// root (one root bit per stage), then the output register.
// Reset is synchronous; busy stays high for one cycle after reset is released.
// Block sizes and offsets are recomputed after a write, through the slot,
// size and end registers in turn. The response side has no backpressure.
// ----------------------------------------------------------------------------
module coefficient_index_order_mapper #(
   parameter int NUM_BLOCKS = coim_pkg::NUM_BLOCKS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_func,
   input  logic [coim_pkg::IDX_W-1:0]       req_flat_index,
   input  logic [coim_pkg::BLK_W-1:0]       req_block_sel,
   input  logic [coim_pkg::RAD_W-1:0]       req_radial_order,
   input  logic [coim_pkg::DEG_W-1:0]       req_degree,
   input  logic [coim_pkg::DEG_W-1:0]       req_azimuth,
   input  logic                             req_real_part,
   output logic                             rsp_strobe,
   output logic [coim_pkg::IDX_W-1:0]       rsp_index_out,
   output logic [coim_pkg::BLK_W-1:0]       rsp_block_out,
   output logic [coim_pkg::RAD_W-1:0]       rsp_radial_out,
   output logic [coim_pkg::DEG_W-1:0]       rsp_degree_out,
   output logic [coim_pkg::DEG_W-1:0]       rsp_azimuth_out,
   output logic                             rsp_real_out,
   output logic                             rsp_range_error,
   input  logic                             csr_we,
   input  logic [coim_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [coim_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import coim_pkg::*;

   localparam int DIV_FIRST  = 2;
   localparam int SQRT_FIRST = DIV_FIRST + RAD_W;
   localparam int NTOK       = SQRT_FIRST + DEG_W;
   localparam int LAT        = NTOK + 5;

   // ---------------------------------------------------------------- config
   logic [RAD_W-1:0]  rc_ff   [NUM_BLOCKS];
   logic [RAD_W-1:0]  rc_in   [NUM_BLOCKS];
   logic [DEG_W-1:0]  md_ff   [NUM_BLOCKS];
   logic [DEG_W-1:0]  md_in   [NUM_BLOCKS];
   logic [SQ_W-1:0]   sq_ff   [NUM_BLOCKS];
   logic [SQ_W-1:0]   sq_in   [NUM_BLOCKS];
   logic [SIZE_W-1:0] size_ff [NUM_BLOCKS];
   logic [SIZE_W-1:0] size_in [NUM_BLOCKS];
   logic [IDX_W-1:0]  end_ff  [NUM_BLOCKS];
   logic [IDX_W-1:0]  end_in  [NUM_BLOCKS];

   always_comb begin
      for (int b = 0; b < NUM_BLOCKS; b++) begin
         rc_in[b] = rc_ff[b];
         md_in[b] = md_ff[b];
         if (csr_we && csr_index == CSR_RADIAL_0 + CSR_IDX_W'(b)) begin
            rc_in[b] = csr_wdata[RAD_W-1:0];
         end
         if (csr_we && csr_index == CSR_DEGREE_0 + CSR_IDX_W'(b)) begin
            md_in[b] = csr_wdata[DEG_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int b = 0; b < NUM_BLOCKS; b++) begin
         if (reset) begin
            rc_ff[b] <= '0;
            md_ff[b] <= '0;
         end else begin
            rc_ff[b] <= rc_in[b];
            md_ff[b] <= md_in[b];
         end
      end
   end

   // Slots per radial order, block sizes and block end offsets, each registered in turn.
   always_comb begin
      logic [DEG_W:0]            w;
      logic [2*DEG_W+1:0]        wsq;
      logic [RAD_W+SQ_W-1:0]     bsize;
      logic [IDX_W-1:0]          acc;
      acc = '0;
      for (int b = 0; b < NUM_BLOCKS; b++) begin
         w          = {1'b0, md_ff[b]} + (DEG_W+1)'(1);
         wsq        = w * w;
         sq_in[b]   = wsq[SQ_W-1:0];
         bsize      = rc_ff[b] * sq_ff[b];
         size_in[b] = bsize[SIZE_W-1:0];
         acc        = acc + IDX_W'(size_ff[b]);
         end_in[b]  = acc;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff   <= sq_in;
      size_ff <= size_in;
      end_ff  <= end_in;
   end

   // Start offset of each block: a disabled block adds nothing.
   logic [IDX_W-1:0] blk_start [NUM_BLOCKS];

   always_comb begin
      blk_start[0] = '0;
      for (int b = 1; b < NUM_BLOCKS; b++) begin
         blk_start[b] = end_ff[b-1];
      end
   end

   // ---------------------------------------------------------------- accept
   logic busy_ff;
   logic take;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy = busy_ff;
   assign take = start && !busy_ff;

   logic    v1_ff;
   req_type r1_ff;
   req_type r1_in;

   always_comb begin
      r1_in.func = func_type'(req_func);
      r1_in.idx  = req_flat_index;
      r1_in.sel  = req_block_sel;
      r1_in.n    = req_radial_order;
      r1_in.l    = req_degree;
      r1_in.m    = req_azimuth;
      r1_in.re   = req_real_part;
   end

   always_ff @(posedge clock) begin
      r1_ff <= r1_in;
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= take;
      end
   end

   // ---------------------------------------------------------- front stages
   front_type f2_ff, f2_in, f3_ff, f3_in, f4_ff, f4_in;

   always_comb begin
      logic             sel_ok;
      logic [RAD_W-1:0] rc_sel;
      logic [DEG_W-1:0] md_sel;
      logic [LSQ_W-1:0] l_sq;
      logic [LSQ_W-1:0] m_term;
      sel_ok = {1'b0, r1_ff.sel} < (BLK_W+1)'(NUM_BLOCKS);
      rc_sel = '0;
      md_sel = '0;
      for (int b = 0; b < NUM_BLOCKS; b++) begin
         if (r1_ff.sel == BLK_W'(b)) begin
            rc_sel = rc_ff[b];
            md_sel = md_ff[b];
         end
      end
      l_sq   = r1_ff.l * r1_ff.l;
      m_term = LSQ_W'({r1_ff.m, 1'b0});
      f2_in.valid = v1_ff;
      f2_in.func  = r1_ff.func;
      f2_in.blk   = r1_ff.sel;
      f2_in.idx   = r1_ff.idx;
      // A real part with m above zero sits one slot before the imaginary one.
      f2_in.err   = !sel_ok || r1_ff.n == '0 || r1_ff.n > rc_sel ||
                    r1_ff.l > md_sel || r1_ff.m > r1_ff.l ||
                    (!r1_ff.re && r1_ff.m == '0);
      f2_in.nm1   = r1_ff.n - RAD_W'(1);
      f2_in.lsqm  = l_sq + m_term - LSQ_W'(r1_ff.re && r1_ff.m != '0);
      f2_in.prod  = '0;
   end

   always_comb begin
      logic [SQ_W-1:0]       sq_sel;
      logic [RAD_W+SQ_W-1:0] p;
      sq_sel = '0;
      for (int b = 0; b < NUM_BLOCKS; b++) begin
         if (f2_ff.blk == BLK_W'(b)) begin
            sq_sel = sq_ff[b];
         end
      end
      p          = f2_ff.nm1 * sq_sel;
      f3_in      = f2_ff;
      f3_in.prod = p[SIZE_W-1:0];
   end

   always_comb begin
      f4_in      = f3_ff;
      f4_in.prod = f3_ff.prod + SIZE_W'(f3_ff.lsqm);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_ff <= '0;
         f3_ff <= '0;
         f4_ff <= '0;
      end else begin
         f2_ff <= f2_in;
         f3_ff <= f3_in;
         f4_ff <= f4_in;
      end
   end

   // ----------------------------------------------------------- back stages
   tok_type          tok_ff [NTOK];
   tok_type          tok_in [NTOK];
   logic [SQ_W-1:0]  tok_sq [NTOK];

   always_comb begin
      for (int i = 0; i < NTOK; i++) begin
         tok_sq[i] = '0;
         for (int b = 0; b < NUM_BLOCKS; b++) begin
            if (tok_ff[i].blk == BLK_W'(b)) begin
               tok_sq[i] = sq_ff[b];
            end
         end
      end
   end

   always_comb begin
      logic [BLK_W-1:0]   found;
      logic               miss;
      logic [IDX_W-1:0]   start_enc;
      logic [IDX_W-1:0]   start_dec;
      logic [IDX_W-1:0]   dvs;
      logic [DEG_W-1:0]   cand;
      logic [2*DEG_W-1:0] csq;
      int                 k;

      // First block whose end lies above the index holds it.
      found     = '0;
      miss      = 1'b1;
      start_enc = '0;
      for (int b = NUM_BLOCKS - 1; b >= 0; b--) begin
         if (f4_ff.idx < end_ff[b]) begin
            found = BLK_W'(b);
            miss  = 1'b0;
         end
         if (f4_ff.blk == BLK_W'(b)) begin
            start_enc = blk_start[b];
         end
      end

      tok_in[0].valid = f4_ff.valid;
      tok_in[0].func  = f4_ff.func;
      tok_in[0].quo   = '0;
      tok_in[0].root  = '0;
      if (f4_ff.func == FUNC_ENCODE) begin
         tok_in[0].err = f4_ff.err;
         tok_in[0].blk = f4_ff.blk;
         tok_in[0].rem = start_enc + IDX_W'(f4_ff.prod);
      end else begin
         tok_in[0].err = miss;
         tok_in[0].blk = found;
         tok_in[0].rem = f4_ff.idx;
      end

      start_dec = '0;
      for (int b = 0; b < NUM_BLOCKS; b++) begin
         if (tok_ff[0].blk == BLK_W'(b)) begin
            start_dec = blk_start[b];
         end
      end
      tok_in[1] = tok_ff[0];
      if (tok_ff[0].func == FUNC_DECODE) begin
         tok_in[1].rem = tok_ff[0].rem - start_dec;
      end

      // Restoring division by (L+1)^2, most significant quotient bit first,
      // then the square root of the remainder, one root bit per stage.
      for (int i = DIV_FIRST; i < NTOK; i++) begin
         tok_in[i] = tok_ff[i-1];
         if (i < SQRT_FIRST) begin
            k   = SQRT_FIRST - 1 - i;
            dvs = IDX_W'(tok_sq[i-1]) << k;
            if (tok_ff[i-1].func == FUNC_DECODE && tok_ff[i-1].rem >= dvs) begin
               tok_in[i].rem    = tok_ff[i-1].rem - dvs;
               tok_in[i].quo[k] = 1'b1;
            end
         end else begin
            k    = NTOK - 1 - i;
            cand = tok_ff[i-1].root | (DEG_W'(1) << k);
            csq  = cand * cand;
            if (IDX_W'(csq) <= tok_ff[i-1].rem) begin
               tok_in[i].root = cand;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NTOK; i++) begin
         if (reset) begin
            tok_ff[i] <= '0;
         end else begin
            tok_ff[i] <= tok_in[i];
         end
      end
   end

   // ---------------------------------------------------------------- output
   logic             strobe_ff;
   logic [IDX_W-1:0] index_ff, index_in;
   logic [BLK_W-1:0] block_ff, block_in;
   logic [RAD_W-1:0] radial_ff, radial_in;
   logic [DEG_W-1:0] degree_ff, degree_in;
   logic [DEG_W-1:0] azimuth_ff, azimuth_in;
   logic             real_ff, real_in;
   logic             error_ff, error_in;

   always_comb begin
      tok_type          last;
      logic [LSQ_W-1:0] r_full;
      logic [DEG_W:0]   r;
      logic [DEG_W:0]   rp1;
      last   = tok_ff[NTOK-1];
      r_full = last.rem[LSQ_W-1:0] - last.root * last.root;
      r      = r_full[DEG_W:0];
      rp1    = r + (DEG_W+1)'(1);

      index_in   = '0;
      block_in   = '0;
      radial_in  = '0;
      degree_in  = '0;
      azimuth_in = '0;
      real_in    = 1'b0;
      error_in   = last.err;
      if (!last.err) begin
         if (last.func == FUNC_ENCODE) begin
            index_in = last.rem;
         end else begin
            block_in  = last.blk;
            radial_in = last.quo + RAD_W'(1);
            degree_in = last.root;
            if (r == '0) begin
               azimuth_in = '0;
               real_in    = 1'b1;
            end else begin
               azimuth_in = rp1[DEG_W:1];
               real_in    = r[0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      index_ff   <= index_in;
      block_ff   <= block_in;
      radial_ff  <= radial_in;
      degree_ff  <= degree_in;
      azimuth_ff <= azimuth_in;
      real_ff    <= real_in;
      error_ff   <= error_in;
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= tok_ff[NTOK-1].valid;
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_index_out   = index_ff;
   assign rsp_block_out   = block_ff;
   assign rsp_radial_out  = radial_ff;
   assign rsp_degree_out  = degree_ff;
   assign rsp_azimuth_out = azimuth_ff;
   assign rsp_real_out    = real_ff;
   assign rsp_range_error = error_ff;

   // ------------------------------------------------------------ assertions
   a_fixed_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(take, LAT))
      else $error("response without a request transfer LAT cycles earlier");

   a_error_clears_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_range_error |->
         rsp_index_out == '0 && rsp_block_out == '0 && rsp_radial_out == '0 &&
         rsp_degree_out == '0 && rsp_azimuth_out == '0 && !rsp_real_out)
      else $error("range error with nonzero result fields");

   a_decoded_orders_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_range_error && rsp_radial_out != '0 |->
         rsp_azimuth_out <= rsp_degree_out && (rsp_real_out || rsp_azimuth_out != '0))
      else $error("decoded azimuth above degree or imaginary part at m zero");

   a_divider_remainder: assert property (@(posedge clock) disable iff (reset)
      tok_ff[SQRT_FIRST-1].valid && tok_ff[SQRT_FIRST-1].func == FUNC_DECODE &&
      !tok_ff[SQRT_FIRST-1].err |->
         tok_ff[SQRT_FIRST-1].rem < IDX_W'(tok_sq[SQRT_FIRST-1]))
      else $error("divider remainder not below the slot count");

endmodule

@@ tb/coefficient_map_checker.sv @@
// ----------------------------------------------------------------------------
// coefficient_map_checker: result checker of the coefficient index mapper
// Follows register writes, predicts the orders or the flat index of every
// accepted request, and compares each response field by field, in order.
// ----------------------------------------------------------------------------
module coefficient_map_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic                            busy,
   input  logic                            req_func,
   input  logic [coim_pkg::IDX_W-1:0]      req_flat_index,
   input  logic [coim_pkg::BLK_W-1:0]      req_block_sel,
   input  logic [coim_pkg::RAD_W-1:0]      req_radial_order,
   input  logic [coim_pkg::DEG_W-1:0]      req_degree,
   input  logic [coim_pkg::DEG_W-1:0]      req_azimuth,
   input  logic                            req_real_part,
   input  logic                            rsp_strobe,
   input  logic [coim_pkg::IDX_W-1:0]      rsp_index_out,
   input  logic [coim_pkg::BLK_W-1:0]      rsp_block_out,
   input  logic [coim_pkg::RAD_W-1:0]      rsp_radial_out,
   input  logic [coim_pkg::DEG_W-1:0]      rsp_degree_out,
   input  logic [coim_pkg::DEG_W-1:0]      rsp_azimuth_out,
   input  logic                            rsp_real_out,
   input  logic                            rsp_range_error,
   input  logic                            csr_we,
   input  logic [coim_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [coim_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              mismatch_count,
   output int                              outstanding
);
   import coim_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic [BLK_W-1:0] blk;
      logic [RAD_W-1:0] radial;
      logic [DEG_W-1:0] degree;
      logic [DEG_W-1:0] azimuth;
      logic             re;
      logic             range_err;
   } coef_orders_type;

   int unsigned     radial_cnt [NUM_BLOCKS_DEF];
   int unsigned     top_degree [NUM_BLOCKS_DEF];
   coef_orders_type expected_maps [$];
   int              fails = 0;

   function automatic int unsigned block_cells(int b);
      return radial_cnt[b] * (top_degree[b] + 1) * (top_degree[b] + 1);
   endfunction

   function automatic coef_orders_type map_coefficient(req_type rq);
      coef_orders_type res;
      int unsigned     rest, cells, slots, s, l, r, acc, n_i, l_i, m_i, sel_i;
      int              b, hit;
      res = '0;
      if (rq.func == FUNC_DECODE) begin
         rest = rq.idx;
         hit  = -1;
         // Disabled blocks have no cells and are stepped over.
         for (b = 0; b < NUM_BLOCKS_DEF; b++) begin
            cells = block_cells(b);
            if (hit < 0 && cells != 0) begin
               if (rest >= cells) rest -= cells;
               else hit = b;
            end
         end
         if (hit < 0) begin
            res.range_err = 1'b1;
         end else begin
            slots = (top_degree[hit] + 1) * (top_degree[hit] + 1);
            s = rest % slots;
            l = 0;
            while ((l + 1) * (l + 1) <= s) l++;
            r = s - l * l;
            res.blk    = BLK_W'(hit);
            res.radial = RAD_W'(rest / slots + 1);
            res.degree = DEG_W'(l);
            if (r == 0) begin
               res.re = 1'b1;
            end else begin
               res.re      = r[0];
               res.azimuth = DEG_W'((r + 1) / 2);
            end
         end
      end else begin
         sel_i = rq.sel;
         n_i   = rq.n;
         l_i   = rq.l;
         m_i   = rq.m;
         if (n_i == 0 || n_i > radial_cnt[sel_i] || l_i > top_degree[sel_i] ||
             m_i > l_i || (!rq.re && m_i == 0)) begin
            res.range_err = 1'b1;
         end else begin
            acc = 0;
            for (b = 0; b < sel_i; b++) acc += block_cells(b);
            slots = (top_degree[sel_i] + 1) * (top_degree[sel_i] + 1);
            acc += (n_i - 1) * slots + l_i * l_i + 2 * m_i;
            // The real part of a nonzero azimuth sits just below the imaginary one.
            if (rq.re && m_i > 0) acc -= 1;
            res.index = IDX_W'(acc);
         end
      end
      return res;
   endfunction

   task automatic check_field(string name, logic [IDX_W-1:0] want, logic [IDX_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin : watch
      req_type         rq;
      coef_orders_type want;
      int              b;
      if (reset) begin
         for (b = 0; b < NUM_BLOCKS_DEF; b++) begin
            radial_cnt[b] = 0;
            top_degree[b] = 0;
         end
         expected_maps.delete();
      end else begin
         if (csr_we) begin
            if (csr_index >= CSR_DEGREE_0)
               top_degree[csr_index - CSR_DEGREE_0] = csr_wdata[DEG_W-1:0];
            else
               radial_cnt[csr_index - CSR_RADIAL_0] = csr_wdata[RAD_W-1:0];
         end
         if (start && !busy) begin
            rq.func = func_type'(req_func);
            rq.idx  = req_flat_index;
            rq.sel  = req_block_sel;
            rq.n    = req_radial_order;
            rq.l    = req_degree;
            rq.m    = req_azimuth;
            rq.re   = req_real_part;
            expected_maps.push_back(map_coefficient(rq));
         end
         if (rsp_strobe) begin
            if (expected_maps.size() == 0) begin
               $display("%0t: response with nothing expected, actual index %0d error %0b",
                        $time, rsp_index_out, rsp_range_error);
               fails++;
            end else begin
               want = expected_maps.pop_front();
               check_field("index_out", want.index, rsp_index_out);
               check_field("block_out", want.blk, rsp_block_out);
               check_field("radial_out", want.radial, rsp_radial_out);
               check_field("degree_out", want.degree, rsp_degree_out);
               check_field("azimuth_out", want.azimuth, rsp_azimuth_out);
               check_field("real_out", want.re, rsp_real_out);
               check_field("range_error", want.range_err, rsp_range_error);
            end
         end
      end
      outstanding    <= expected_maps.size();
      mismatch_count <= fails;
   end

endmodule

@@ tb/coefficient_index_order_mapper_tb.sv @@
// ----------------------------------------------------------------------------
// coefficient_index_order_mapper_tb: testbench of the coefficient index mapper
// Directed requests at the field and block extremes, then random decode and
// encode requests over several block layouts, with random sender gaps.
// ----------------------------------------------------------------------------
module coefficient_index_order_mapper_tb;
   import coim_pkg::*;

   localparam int LATENCY        = 7 + RAD_W + DEG_W;
   localparam int WATCHDOG_LIMIT = 2000;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  start            = 1'b0;
   logic                  busy;
   logic                  req_func         = 1'b0;
   logic [IDX_W-1:0]      req_flat_index   = '0;
   logic [BLK_W-1:0]      req_block_sel    = '0;
   logic [RAD_W-1:0]      req_radial_order = '0;
   logic [DEG_W-1:0]      req_degree       = '0;
   logic [DEG_W-1:0]      req_azimuth      = '0;
   logic                  req_real_part    = 1'b0;
   logic                  rsp_strobe;
   logic [IDX_W-1:0]      rsp_index_out;
   logic [BLK_W-1:0]      rsp_block_out;
   logic [RAD_W-1:0]      rsp_radial_out;
   logic [DEG_W-1:0]      rsp_degree_out;
   logic [DEG_W-1:0]      rsp_azimuth_out;
   logic                  rsp_real_out;
   logic                  rsp_range_error;
   logic                  csr_we           = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index        = '0;
   logic [CSR_DATA_W-1:0] csr_wdata        = '0;

   int mismatch_count;
   int outstanding;
   int radial_cfg [NUM_BLOCKS_DEF];
   int degree_cfg [NUM_BLOCKS_DEF];
   bit idle_on      = 1'b1;
   int quiet_cycles = 0;

   coefficient_index_order_mapper dut (.*);

   coefficient_map_checker map_check (.*);

   always #1 clock = ~clock;

   // Ends the run when no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic pause(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic send_item(func_type f, logic [IDX_W-1:0] idx, logic [BLK_W-1:0] sel,
                            logic [RAD_W-1:0] n, logic [DEG_W-1:0] l,
                            logic [DEG_W-1:0] m, logic re);
      if (idle_on && $urandom_range(0, 3) == 0) pause($urandom_range(1, 18));
      start            <= 1'b1;
      req_func         <= f;
      req_flat_index   <= idx;
      req_block_sel    <= sel;
      req_radial_order <= n;
      req_degree       <= l;
      req_azimuth      <= m;
      req_real_part    <= re;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Writes all eight registers from radial_cfg and degree_cfg while idle.
   task automatic configure();
      logic [CSR_DATA_W-1:0] wdata;
      int                    b;
      drain();
      repeat (LATENCY) @(posedge clock);
      for (b = 0; b < NUM_BLOCKS_DEF; b++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_RADIAL_0 + CSR_IDX_W'(b);
         csr_wdata <= CSR_DATA_W'(radial_cfg[b]);
         @(posedge clock);
      end
      for (b = 0; b < NUM_BLOCKS_DEF; b++) begin
         // The top bit lies above the degree width and must be dropped.
         wdata                 = CSR_DATA_W'(degree_cfg[b]);
         wdata[CSR_DATA_W-1]   = 1'($urandom_range(0, 1));
         csr_we    <= 1'b1;
         csr_index <= CSR_DEGREE_0 + CSR_IDX_W'(b);
         csr_wdata <= wdata;
         @(posedge clock);
      end
      csr_we <= 1'b0;
      repeat (4) @(posedge clock);
   endtask

   function automatic int cells_of(int b);
      return radial_cfg[b] * (degree_cfg[b] + 1) * (degree_cfg[b] + 1);
   endfunction

   task automatic random_decode();
      int               total, choice, b;
      logic [IDX_W-1:0] idx;
      total = 0;
      for (b = 0; b < NUM_BLOCKS_DEF; b++) total += cells_of(b);
      choice = $urandom_range(0, 9);
      if (total != 0 && choice < 7) idx = IDX_W'($urandom_range(0, total - 1));
      else if (choice < 8) idx = IDX_W'(total + $urandom_range(0, 3) - 2);
      else idx = IDX_W'($urandom);
      send_item(FUNC_DECODE, idx, BLK_W'($urandom), RAD_W'($urandom), DEG_W'($urandom),
                DEG_W'($urandom), 1'($urandom));
   endtask

   task automatic random_encode();
      int b, sel, n, l, m, re;
      bit any_on;
      any_on = 1'b0;
      for (b = 0; b < NUM_BLOCKS_DEF; b++) if (radial_cfg[b] != 0) any_on = 1'b1;
      if (any_on && $urandom_range(0, 9) < 8) begin
         do sel = $urandom_range(0, NUM_BLOCKS_DEF - 1); while (radial_cfg[sel] == 0);
         n  = $urandom_range(1, radial_cfg[sel]);
         l  = $urandom_range(0, degree_cfg[sel]);
         m  = $urandom_range(0, l);
         re = (m == 0) ? ($urandom_range(0, 7) != 0) : $urandom_range(0, 1);
      end else begin
         sel = $urandom_range(0, 3);
         n   = $urandom_range(0, 63);
         l   = $urandom_range(0, 31);
         m   = $urandom_range(0, 31);
         re  = $urandom_range(0, 1);
      end
      send_item(FUNC_ENCODE, IDX_W'($urandom), BLK_W'(sel), RAD_W'(n), DEG_W'(l),
                DEG_W'(m), 1'(re));
   endtask

   initial begin
      int ph, k, b, count;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset layout: every block disabled, so both directions report range errors.
      send_item(FUNC_DECODE, '0, '0, '0, '0, '0, 1'b0);
      send_item(FUNC_ENCODE, '0, 2'd0, 6'd1, 5'd0, 5'd0, 1'b1);

      // Block 1 disabled between two enabled ones; block 3 holds a single cell.
      radial_cfg = '{63, 0, 5, 1};
      degree_cfg = '{31, 7, 2, 0};
      configure();
      send_item(FUNC_DECODE, 18'd0, '0, '0, '0, '0, 1'b0);
      send_item(FUNC_DECODE, 18'd1, '0, '0, '0, '0, 1'b0);
      send_item(FUNC_DECODE, 18'd2, '0, '0, '0, '0, 1'b0);
      send_item(FUNC_DECODE, 18'd3, '0, '0, '0, '0, 1'b0);
      send_item(FUNC_DECODE, 18'd64511, '0, '0, '0, '0, 1'b0);
      send_item(FUNC_DECODE, 18'd64512, '1, '1, '1, '1, 1'b1);
      send_item(FUNC_DECODE, 18'd64556, '0, '0, '0, '0, 1'b0);
      send_item(FUNC_DECODE, 18'd64557, '0, '0, '0, '0, 1'b0);
      send_item(FUNC_DECODE, 18'd64558, '0, '0, '0, '0, 1'b0);
      send_item(FUNC_DECODE, '1, '0, '0, '0, '0, 1'b0);
      send_item(FUNC_ENCODE, '0, 2'd0, 6'd1, 5'd0, 5'd0, 1'b1);
      send_item(FUNC_ENCODE, '1, 2'd0, 6'd63, 5'd31, 5'd31, 1'b0);
      send_item(FUNC_ENCODE, '0, 2'd0, 6'd63, 5'd31, 5'd31, 1'b1);
      send_item(FUNC_ENCODE, '0, 2'd1, 6'd1, 5'd0, 5'd0, 1'b1);
      send_item(FUNC_ENCODE, '0, 2'd2, 6'd5, 5'd2, 5'd2, 1'b1);
      send_item(FUNC_ENCODE, '0, 2'd3, 6'd1, 5'd0, 5'd0, 1'b1);
      send_item(FUNC_ENCODE, '0, 2'd0, 6'd0, 5'd0, 5'd0, 1'b1);
      send_item(FUNC_ENCODE, '0, 2'd2, 6'd6, 5'd0, 5'd0, 1'b1);
      send_item(FUNC_ENCODE, '0, 2'd2, 6'd1, 5'd3, 5'd0, 1'b1);
      send_item(FUNC_ENCODE, '0, 2'd0, 6'd1, 5'd3, 5'd4, 1'b1);
      send_item(FUNC_ENCODE, '0, 2'd0, 6'd1, 5'd3, 5'd0, 1'b0);
      send_item(FUNC_ENCODE, '0, 2'd3, 6'd1, 5'd1, 5'd0, 1'b1);
      send_item(FUNC_ENCODE, '0, 2'd3, 6'd63, 5'd31, 5'd31, 1'b1);

      for (ph = 0; ph < 8; ph++) begin
         for (b = 0; b < NUM_BLOCKS_DEF; b++) begin
            case (ph)
               0: begin
                  radial_cfg[b] = 63;
                  degree_cfg[b] = 31;
               end
               1: begin
                  radial_cfg[b] = 63;
                  degree_cfg[b] = 0;
               end
               2: begin
                  radial_cfg[b] = 0;
                  degree_cfg[b] = 31;
               end
               default: begin
                  radial_cfg[b] = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 63);
                  degree_cfg[b] = $urandom_range(0, 31);
               end
            endcase
         end
         configure();
         if (ph == 7) idle_on = 1'b0;
         count = (ph == 2) ? 50 : 150;
         for (k = 0; k < count; k++) begin
            if (ph == 4 && k == 75) drain();
            if ($urandom_range(0, 1) == 0) random_decode();
            else random_encode();
         end
      end

      drain();
      repeat (LATENCY + 4) @(posedge clock);
      if (mismatch_count == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ coefficient_index_order_mapper.f @@
rtl/coim_pkg.sv
rtl/coefficient_index_order_mapper.sv
tb/coefficient_map_checker.sv
tb/coefficient_index_order_mapper_tb.sv
